>>> hw/rtl/lvs_pkg.sv
// Shared types and constants for the Laplacian variance sharpness block.
// Used by lvs_front, lvs_queue, lvs_back and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lvs_pkg;

  // Default configuration and parameter values.
  localparam int MAX_HALF_WIDTH_DEF = 1920;
  localparam int GREY_FRAC_BITS_DEF = 8;
  localparam logic [11:0] FULL_WIDTH_RST  = 12'd1920;
  localparam logic [12:0] FULL_HEIGHT_RST = 13'd1080;

  // Field widths fixed by the interface.
  localparam int COL_W   = 12;
  localparam int ROW_W   = 13;
  localparam int X_W     = COL_W - 1;
  localparam int Y_W     = ROW_W - 1;
  localparam int CFG_W   = 13;
  localparam int VAR_W   = 36;
  localparam int COUNT_W = 24;
  localparam int SUM_W   = 64;
  localparam int WIDE_W  = 128;
  localparam int Q_DEPTH = 8;

  // Configuration register indexes.
  typedef enum logic {
    REG_FULL_WIDTH  = 1'b0,
    REG_FULL_HEIGHT = 1'b1
  } cfg_reg_t;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_DIM = 1'b1;

  // Control part of one queued point.
  typedef struct packed {
    logic           is_point;
    logic           frame_end;
    logic           dims_ok;
    logic           y_ge2;
    logic           row_last;
    logic [X_W-1:0] x;
  } pt_ctrl_t;

  // Luma weight rounded from thousandths to the given fraction bits.
  function automatic int unsigned luma_weight(input int unsigned milli,
                                              input int unsigned frac);
    return ((milli << frac) * 2 + 1000) / 2000;
  endfunction

endpackage

>>> hw/rtl/laplacian_variance_sharpness.sv
// Top level of the Laplacian variance sharpness block.
// Depends on lvs_pkg, lvs_front, lvs_queue and lvs_back.
`timescale 1ns / 1ps

// Usage:
// Pixels of a full frame enter on the in channel (red, green, blue) in raster
// order under valid/ready. The block keeps even columns of even rows, turns
// them into grey values and forms the 4-neighbour Laplacian on interior points.
// After the last pixel of a frame one item leaves on the out channel with the
// variance (16 fraction bits), a status and the number of points used.
// The user writes the frame width and height registers through cfg_write,
// cfg_index and cfg_data while the block is idle; the block does not check it.
// Throughput: the front takes one pixel per cycle while its 8-entry queue has
// room. The back part takes each decimated point in turn through pop and line
// store read, Laplacian, square and accumulate, so bursts of points on even
// rows can stall the input until odd rows let the queue drain.
// After the last pixel of a valid frame with points, the back part finishes
// the last point, runs the bit-serial multiplier (over the bits of the sum
// magnitude, then of the count, twice), the restoring divider over the
// 128-bit numerator and sets the result; queued points are handled first.
// Reset clears positions, sums and the queue and restores the default frame
// size. While out_ready is low the result holds and the back part waits; the
// input keeps flowing until the queue fills.

module laplacian_variance_sharpness #(
  parameter int MAX_HALF_WIDTH = lvs_pkg::MAX_HALF_WIDTH_DEF,
  parameter int GREY_FRAC_BITS = lvs_pkg::GREY_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [lvs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lvs_pkg::VAR_W-1:0]     variance,
  output logic                          status,
  output logic [lvs_pkg::COUNT_W-1:0]   point_count
);

  localparam int GREY_W = GREY_FRAC_BITS + 9;
  localparam int CTRL_W = $bits(lvs_pkg::pt_ctrl_t);
  localparam int QW     = CTRL_W + GREY_W;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  lvs_pkg::pt_ctrl_t push_ctrl;
  logic [GREY_W-1:0] push_grey;
  logic [QW-1:0]     head_data;
  lvs_pkg::pt_ctrl_t head_ctrl;
  logic [GREY_W-1:0] head_grey;

  assign head_ctrl = lvs_pkg::pt_ctrl_t'(head_data[CTRL_W-1:0]);
  assign head_grey = head_data[QW-1:CTRL_W];

  // Front: configuration, position and grey conversion.
  lvs_front #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
    .GREY_FRAC_BITS(GREY_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctrl    (push_ctrl),
    .q_grey    (push_grey)
  );

  // Queue of points and frame ends.
  lvs_queue #(
    .W    (QW),
    .DEPTH(lvs_pkg::Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_grey, push_ctrl}),
    .pop       (q_pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: line store, sums and variance.
  lvs_back #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
    .GREY_FRAC_BITS(GREY_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_ctrl      (head_ctrl),
    .q_grey      (head_grey),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .variance    (variance),
    .status      (status),
    .point_count (point_count)
  );

endmodule

>>> hw/rtl/lvs_queue.sv
// Small register queue between the front and back parts.
// Depends on lvs_pkg for the default depth.
`timescale 1ns / 1ps

module lvs_queue #(
  parameter int W     = 16,
  parameter int DEPTH = lvs_pkg::Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full      = (fill == (PW+1)'(DEPTH));
  assign empty     = (fill == '0);
  assign head_data = slots[rd_ptr];

  // Storage for queued items.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/lvs_front.sv
// Front part: configuration registers, raster position, decimation and grey.
// Depends on lvs_pkg.
`timescale 1ns / 1ps

module lvs_front #(
  parameter int MAX_HALF_WIDTH = lvs_pkg::MAX_HALF_WIDTH_DEF,
  parameter int GREY_FRAC_BITS = lvs_pkg::GREY_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [lvs_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  input  logic                         q_full,
  output logic                         q_push,
  output lvs_pkg::pt_ctrl_t            q_ctrl,
  output logic [GREY_FRAC_BITS+8:0]    q_grey
);

  localparam int GREY_W = GREY_FRAC_BITS + 9;
  localparam int XW = lvs_pkg::X_W;
  localparam int YW = lvs_pkg::Y_W;
  localparam int unsigned WR = lvs_pkg::luma_weight(299, GREY_FRAC_BITS);
  localparam int unsigned WG = lvs_pkg::luma_weight(587, GREY_FRAC_BITS);
  localparam int unsigned WB = lvs_pkg::luma_weight(114, GREY_FRAC_BITS);

  logic [lvs_pkg::COL_W-1:0] frame_width;
  logic [lvs_pkg::ROW_W-1:0] frame_height;
  logic [lvs_pkg::COL_W-1:0] column_pos;
  logic [lvs_pkg::ROW_W-1:0] row_pos;

  logic [XW-1:0] half_w;
  logic [YW-1:0] half_h;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic          dims_ok;
  logic          take;
  logic          row_end;
  logic          frame_end;
  logic          accept;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lvs_pkg::FULL_WIDTH_RST;
      frame_height <= lvs_pkg::FULL_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (lvs_pkg::cfg_reg_t'(cfg_index))
        lvs_pkg::REG_FULL_WIDTH:  frame_width  <= cfg_data[lvs_pkg::COL_W-1:0];
        lvs_pkg::REG_FULL_HEIGHT: frame_height <= cfg_data[lvs_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Decimated size, position and classification of the current item.
  always_comb begin
    half_w    = frame_width[lvs_pkg::COL_W-1:1];
    half_h    = frame_height[lvs_pkg::ROW_W-1:1];
    x         = column_pos[lvs_pkg::COL_W-1:1];
    y         = row_pos[lvs_pkg::ROW_W-1:1];
    dims_ok   = (half_w >= XW'(3)) && (half_h >= YW'(3)) &&
                (32'(half_w) <= 32'(MAX_HALF_WIDTH));
    take      = dims_ok && !column_pos[0] && !row_pos[0] &&
                (x < half_w) && (y < half_h);
    row_end   = ({1'b0, column_pos} + 13'd1) >= {1'b0, frame_width};
    frame_end = row_end && (({1'b0, row_pos} + 14'd1) >= {1'b0, frame_height});
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (take || frame_end);

  // Queue entry for a point or a frame end.
  always_comb begin
    q_ctrl.is_point  = take;
    q_ctrl.frame_end = frame_end;
    q_ctrl.dims_ok   = dims_ok;
    q_ctrl.y_ge2     = (y >= YW'(2));
    q_ctrl.row_last  = ((x + XW'(1)) == half_w);
    q_ctrl.x         = x;
    q_grey           = GREY_W'(32'(red) * WR + 32'(green) * WG + 32'(blue) * WB);
  end

  // Raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_pos <= '0;
        row_pos    <= frame_end ? '0 : row_pos + lvs_pkg::ROW_W'(1);
      end else begin
        column_pos <= column_pos + lvs_pkg::COL_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/lvs_back.sv
// Back part: line store, Laplacian window, sums and the frame-end variance unit.
// Depends on lvs_pkg.
`timescale 1ns / 1ps

module lvs_back #(
  parameter int MAX_HALF_WIDTH = lvs_pkg::MAX_HALF_WIDTH_DEF,
  parameter int GREY_FRAC_BITS = lvs_pkg::GREY_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  lvs_pkg::pt_ctrl_t             q_ctrl,
  input  logic [GREY_FRAC_BITS+8:0]     q_grey,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lvs_pkg::VAR_W-1:0]     variance,
  output logic                          status,
  output logic [lvs_pkg::COUNT_W-1:0]   point_count
);

  localparam int GREY_W = GREY_FRAC_BITS + 9;
  localparam int LAP_W  = GREY_W + 3;
  localparam int SQ_W   = 2 * LAP_W;
  localparam int AW     = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
  localparam int XW     = lvs_pkg::X_W;
  localparam int SW     = lvs_pkg::SUM_W;
  localparam int WW     = lvs_pkg::WIDE_W;
  localparam int CW     = lvs_pkg::COUNT_W;
  localparam int VW     = lvs_pkg::VAR_W;
  localparam int DW     = 2 * CW;
  localparam int RW     = DW + 1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_CALC = 12'b000000000010,
    S_SQ   = 12'b000000000100,
    S_ACC  = 12'b000000001000,
    S_FIN  = 12'b000000010000,
    S_MUL1 = 12'b000000100000,
    S_MUL2 = 12'b000001000000,
    S_MUL3 = 12'b000010000000,
    S_SUB  = 12'b000100000000,
    S_DIV  = 12'b001000000000,
    S_RES  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } back_state_t;

  back_state_t state;

  // Line store: each entry holds {upper, middle} grey values of one column.
  logic [2*GREY_W-1:0] line_mem [MAX_HALF_WIDTH];
  logic [2*GREY_W-1:0] rd_q;
  logic                rd_en;
  logic [AW-1:0]       wr_addr;
  logic [2*GREY_W-1:0] wr_data;
  logic                wr_en;

  lvs_pkg::pt_ctrl_t   cur;
  logic [GREY_W-1:0]   cur_grey;

  // Sliding window over the middle and upper rows, and the two latest greys.
  logic [GREY_W-1:0] m1;
  logic [GREY_W-1:0] m2;
  logic [GREY_W-1:0] u1;
  logic [GREY_W-1:0] rl0;
  logic [GREY_W-1:0] rl1;

  logic signed [LAP_W-1:0] lap_r;
  logic signed [SQ_W-1:0]  sq_r;
  logic signed [LAP_W-1:0] lap_next;

  logic [SW-1:0] lap_sum;
  logic [SW-1:0] lap_square_sum;
  logic [CW-1:0] lap_count;
  logic [SW-1:0] sum_mag;

  // Serial multiplier, subtract and restoring divider.
  logic [WW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [WW-1:0] mul_acc;
  logic [WW-1:0] prod_sq;
  logic [WW-1:0] prod_ns;
  logic [DW-1:0] divisor;
  logic [WW-1:0] num;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_sh;
  logic [6:0]    div_cnt;
  logic [WW-1:0] quot_sh;

  logic x_ge1;
  logic x_ge2;

  assign x_ge1   = (cur.x >= XW'(1));
  assign x_ge2   = (cur.x >= XW'(2));
  assign sum_mag = lap_sum[SW-1] ? (SW'(0) - lap_sum) : lap_sum;
  assign rem_sh  = {rem[RW-2:0], num[WW-1]};
  assign quot_sh = num >> (2 * GREY_FRAC_BITS);

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign rd_en     = q_pop && q_ctrl.is_point;
  assign out_valid = (state == S_OUT);

  // Laplacian at the previous column of the previous row.
  assign lap_next = (LAP_W'(signed'({3'b000, m1})) <<< 2)
                  - LAP_W'(signed'({3'b000, u1}))
                  - LAP_W'(signed'({3'b000, rl0}))
                  - LAP_W'(signed'({3'b000, m2}))
                  - LAP_W'(signed'({3'b000, rd_q[GREY_W-1:0]}));

  // Line store write selection: shifted column, then the two row-end columns.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(cur.x);
    wr_data = {m2, rl1};
    unique case (state)
      S_CALC: begin
        wr_en   = cur.is_point && x_ge2;
        wr_addr = AW'(cur.x - XW'(2));
        wr_data = {m2, rl1};
      end
      S_SQ: begin
        wr_en   = cur.is_point && cur.row_last && x_ge1;
        wr_addr = AW'(cur.x - XW'(1));
        wr_data = {m2, rl1};
      end
      S_ACC: begin
        wr_en   = cur.is_point && cur.row_last;
        wr_addr = AW'(cur.x);
        wr_data = {m1, rl0};
      end
      default: ;
    endcase
  end

  // Line store ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= line_mem[AW'(q_ctrl.x)];
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          cur      <= q_ctrl;
          cur_grey <= q_grey;
        end
      end
      S_CALC: begin
        lap_r <= lap_next;
        m2    <= m1;
        m1    <= rd_q[GREY_W-1:0];
        u1    <= rd_q[2*GREY_W-1:GREY_W];
      end
      S_SQ: begin
        sq_r <= lap_r * lap_r;
      end
      S_FIN: begin
        mul_a   <= WW'(sum_mag);
        mul_b   <= sum_mag;
        mul_acc <= '0;
      end
      S_MUL1, S_MUL2, S_MUL3: begin
        if (mul_b == '0) begin
          mul_acc <= '0;
          if (state == S_MUL1) begin
            prod_sq <= mul_acc;
            mul_a   <= WW'(lap_square_sum);
            mul_b   <= SW'(lap_count);
          end else if (state == S_MUL2) begin
            prod_ns <= mul_acc;
            mul_a   <= WW'(lap_count);
            mul_b   <= SW'(lap_count);
          end else begin
            divisor <= mul_acc[DW-1:0];
          end
        end else begin
          if (mul_b[0]) begin
            mul_acc <= mul_acc + mul_a;
          end
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      S_SUB: begin
        num     <= (prod_ns - prod_sq) << 16;
        rem     <= '0;
        div_cnt <= 7'd127;
      end
      S_DIV: begin
        if (rem_sh >= RW'(divisor)) begin
          rem <= rem_sh - RW'(divisor);
          num <= {num[WW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          num <= {num[WW-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 7'd1;
      end
      default: ;
    endcase
  end

  // Control, sums and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rl0            <= '0;
      rl1            <= '0;
      lap_sum        <= '0;
      lap_square_sum <= '0;
      lap_count      <= '0;
      variance       <= '0;
      status         <= lvs_pkg::STATUS_OK;
      point_count    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= q_ctrl.is_point ? S_CALC : S_FIN;
          end
        end
        S_CALC: begin
          rl1   <= rl0;
          rl0   <= cur_grey;
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (cur.y_ge2 && x_ge2) begin
            lap_sum        <= lap_sum + SW'(lap_r);
            lap_square_sum <= lap_square_sum + SW'(unsigned'(sq_r));
            if (lap_count != {CW{1'b1}}) begin
              lap_count <= lap_count + CW'(1);
            end
          end
          state <= cur.frame_end ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (!cur.dims_ok) begin
            variance    <= '0;
            status      <= lvs_pkg::STATUS_BAD_DIM;
            point_count <= '0;
            state       <= S_OUT;
          end else if (lap_count == '0) begin
            variance    <= '0;
            status      <= lvs_pkg::STATUS_OK;
            point_count <= '0;
            state       <= S_OUT;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_b == '0) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_b == '0) begin
            state <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_b == '0) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (prod_ns < prod_sq) begin
            variance    <= '0;
            status      <= lvs_pkg::STATUS_OK;
            point_count <= lap_count;
            state       <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          variance    <= (|quot_sh[WW-1:VW]) ? {VW{1'b1}} : quot_sh[VW-1:0];
          status      <= lvs_pkg::STATUS_OK;
          point_count <= lap_count;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            rl0            <= '0;
            rl1            <= '0;
            lap_sum        <= '0;
            lap_square_sum <= '0;
            lap_count      <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for laplacian_variance_sharpness.
// Frames of RGB pixels stream under random handshake gaps; each frame result is compared
// with a behavioral focus predictor or a table value. Depends on lvs_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE = 400;
  localparam int HALF_MAX = 1920;
  localparam logic [63:0] VAR_SAT = 64'hF_FFFF_FFFF;
  localparam int WT_R = 77;
  localparam int WT_G = 150;
  localparam int WT_B = 29;
  localparam int N_DIRECTED = 11;

  typedef enum int {PIX_ZERO, PIX_FULL, PIX_CHECK, PIX_RANDOM} pix_kind_t;

  typedef struct {
    logic [lvs_pkg::VAR_W-1:0]   var_q;
    logic                        stat;
    logic [lvs_pkg::COUNT_W-1:0] cnt;
  } focus_t;

  typedef struct {
    int        w;
    int        h;
    pix_kind_t kind;
    bit        typed;
    focus_t    res;
  } frame_row_t;

  logic clk, rst;
  logic cfg_write, cfg_index;
  logic [lvs_pkg::CFG_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [7:0] red, green, blue;
  logic out_valid, out_ready;
  logic [lvs_pkg::VAR_W-1:0] variance;
  logic status;
  logic [lvs_pkg::COUNT_W-1:0] point_count;

  laplacian_variance_sharpness u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .variance(variance), .status(status), .point_count(point_count)
  );

  // Predictor state: frame size, line stores, raster position and sums.
  logic [11:0] pr_width;
  logic [12:0] pr_height;
  logic [15:0] upper_mem [HALF_MAX];
  logic [15:0] middle_mem [HALF_MAX];
  logic [15:0] lower0, lower1;
  int unsigned col, row;
  logic [63:0] lap_total, lap_sq_total;
  logic [23:0] lap_points;

  focus_t frame_results[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  bit calm = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [lvs_pkg::VAR_W-1:0] focus_variance();
    logic [63:0] mag;
    logic [127:0] sq_of_sum, scaled, num, den, quo;
    if (lap_points == 0) return '0;
    mag = lap_total[63] ? -lap_total : lap_total;
    sq_of_sum = 128'(mag) * 128'(mag);
    scaled = 128'(lap_points) * 128'(lap_sq_total);
    if (scaled < sq_of_sum) return '0;
    num = (scaled - sq_of_sum) << 16;
    den = 128'(lap_points) * 128'(lap_points);
    quo = (num / den) >> 16;
    if (quo > 128'(VAR_SAT)) return VAR_SAT[lvs_pkg::VAR_W-1:0];
    return quo[lvs_pkg::VAR_W-1:0];
  endfunction

  task automatic clear_frame();
    lower0 = 0; lower1 = 0; col = 0; row = 0;
    lap_total = 0; lap_sq_total = 0; lap_points = 0;
  endtask

  // Advance the predictor by one pixel; done is set when it ends a frame.
  task automatic predict_pixel(input logic [7:0] r, g, b, output bit done,
                               output focus_t res);
    int unsigned sw, sh, x, y;
    logic [15:0] grey;
    longint lap;
    bit dims_ok;
    done = 0;
    sw = 32'(pr_width >> 1);
    sh = 32'(pr_height >> 1);
    dims_ok = sw >= 3 && sw <= HALF_MAX && sh >= 3;
    if (dims_ok && col[0] == 0 && row[0] == 0 && (col >> 1) < sw && (row >> 1) < sh) begin
      x = col >> 1;
      y = row >> 1;
      grey = 16'(r * WT_R + g * WT_G + b * WT_B);
      // Laplacian on interior points once two rows and columns are stored.
      if (y >= 2 && x >= 2) begin
        lap = 4 * longint'(middle_mem[x-1]) - longint'(upper_mem[x-1])
            - longint'(lower0) - longint'(middle_mem[x-2]) - longint'(middle_mem[x]);
        lap_total += 64'(lap);
        lap_sq_total += 64'(lap * lap);
        if (lap_points != 24'hFFFFFF) lap_points++;
      end
      if (x >= 2) begin
        upper_mem[x-2] = middle_mem[x-2];
        middle_mem[x-2] = lower1;
      end
      if (x + 1 == sw) begin
        if (x >= 1) begin
          upper_mem[x-1] = middle_mem[x-1];
          middle_mem[x-1] = lower0;
        end
        upper_mem[x] = middle_mem[x];
        middle_mem[x] = grey;
      end
      lower1 = lower0;
      lower0 = grey;
    end
    // Raster position and frame end.
    if (col + 1 >= pr_width) begin
      col = 0;
      if (row + 1 >= pr_height) begin
        done = 1;
        res.var_q = dims_ok ? focus_variance() : '0;
        res.stat = dims_ok ? lvs_pkg::STATUS_OK : lvs_pkg::STATUS_BAD_DIM;
        res.cnt = dims_ok ? lap_points : '0;
        clear_frame();
      end else begin
        row = (row + 1) & 32'h1FFF;
      end
    end else begin
      col = (col + 1) & 32'hFFF;
    end
  endtask

  // Write both size registers on consecutive edges while the block is idle.
  task automatic set_size(input int w, input int h);
    cfg_write <= 1;
    cfg_index <= lvs_pkg::REG_FULL_WIDTH;
    cfg_data <= lvs_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_index <= lvs_pkg::REG_FULL_HEIGHT;
    cfg_data <= lvs_pkg::CFG_W'(h);
    @(posedge clk);
    cfg_write <= 0;
    pr_width = 12'(w);
    pr_height = 13'(h);
  endtask

  // Offer one pixel after a random gap and wait for it to be taken.
  task automatic send_pixel(input logic [7:0] r, g, b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Let the block drain fully, set the frame size, then stream one frame.
  task automatic run_frame(input frame_row_t fr);
    bit done;
    focus_t res;
    logic [7:0] r, g, b;
    in_valid <= 0;
    @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    set_size(fr.w, fr.h);
    calm = ($urandom_range(0, 3) == 0);
    for (int py = 0; py < fr.h; py++) begin
      for (int px = 0; px < fr.w; px++) begin
        case (fr.kind)
          PIX_ZERO: begin r = 0; g = 0; b = 0; end
          PIX_FULL: begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
          PIX_CHECK: begin
            r = (((px >> 1) + (py >> 1)) & 1) ? 8'hFF : 8'h00;
            g = r;
            b = r;
          end
          default: begin
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
          end
        endcase
        // The expectation is queued before the pixel can be taken.
        predict_pixel(r, g, b, done, res);
        if (done) begin
          if (fr.typed) frame_results.push_back(fr.res);
          else frame_results.push_back(res);
        end
        send_pixel(r, g, b);
      end
    end
  endtask

  // Result side: random stalls, with calm stretches.
  initial begin
    int stall;
    out_ready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    focus_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_results.size() == 0) begin
        report("result with no frame pending");
      end else begin
        want = frame_results.pop_front();
        if (variance !== want.var_q)
          report($sformatf("variance %0d, want %0d", variance, want.var_q));
        if (status !== want.stat)
          report($sformatf("status %0d, want %0d", status, want.stat));
        if (point_count !== want.cnt)
          report($sformatf("point_count %0d, want %0d", point_count, want.cnt));
      end
    end
  end

  initial begin
    frame_row_t directed [N_DIRECTED] = '{
      '{1, 1, PIX_ZERO, 1, '{0, lvs_pkg::STATUS_BAD_DIM, 0}},
      '{6, 6, PIX_FULL, 1, '{0, lvs_pkg::STATUS_OK, 1}},
      '{7, 7, PIX_CHECK, 0, '{0, lvs_pkg::STATUS_OK, 0}},
      '{8, 8, PIX_FULL, 1, '{0, lvs_pkg::STATUS_OK, 4}},
      '{5, 8, PIX_RANDOM, 1, '{0, lvs_pkg::STATUS_BAD_DIM, 0}},
      '{8, 5, PIX_RANDOM, 1, '{0, lvs_pkg::STATUS_BAD_DIM, 0}},
      '{12, 10, PIX_CHECK, 0, '{0, lvs_pkg::STATUS_OK, 0}},
      '{12, 10, PIX_RANDOM, 0, '{0, lvs_pkg::STATUS_OK, 0}},
      '{12, 1, PIX_RANDOM, 1, '{0, lvs_pkg::STATUS_BAD_DIM, 0}},
      '{1, 12, PIX_FULL, 1, '{0, lvs_pkg::STATUS_BAD_DIM, 0}},
      '{9, 7, PIX_RANDOM, 0, '{0, lvs_pkg::STATUS_OK, 0}}
    };
    frame_row_t fr;
    rst <= 1;
    cfg_write <= 0;
    cfg_index <= lvs_pkg::REG_FULL_WIDTH;
    cfg_data <= '0;
    in_valid <= 0;
    red <= 0;
    green <= 0;
    blue <= 0;
    pr_width = lvs_pkg::FULL_WIDTH_RST;
    pr_height = lvs_pkg::FULL_HEIGHT_RST;
    for (int i = 0; i < HALF_MAX; i++) begin
      upper_mem[i] = 0;
      middle_mem[i] = 0;
    end
    clear_frame();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed frames: size extremes, flat and checker images, bad sizes.
    foreach (directed[i]) run_frame(directed[i]);

    // Random frames, mostly small valid sizes with some out of range.
    while (items_sent < 1900) begin
      fr.typed = 0;
      fr.res = '{0, lvs_pkg::STATUS_OK, 0};
      case ($urandom_range(0, 9))
        0: begin fr.w = $urandom_range(1, 5); fr.h = $urandom_range(1, 12); end
        1: begin fr.w = $urandom_range(6, 20); fr.h = $urandom_range(1, 5); end
        default: begin fr.w = $urandom_range(6, 30); fr.h = $urandom_range(6, 16); end
      endcase
      case ($urandom_range(0, 9))
        0: fr.kind = PIX_FULL;
        1: fr.kind = PIX_CHECK;
        default: fr.kind = PIX_RANDOM;
      endcase
      run_frame(fr);
    end
    in_valid <= 0;

    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
